/* src/owr_pkg.sv */
// Shared codes and types for the obstacle-avoiding wire router.
// No dependencies; used by owr_cell and the top level.
package owr_pkg;

  // Input operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_ROUTE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_LINE   = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // Reset value of the clearance register
  localparam logic [7:0] CLEARANCE_RESET = 8'd5;

  // Control part of a search token travelling down the cell chain
  typedef struct packed {
    logic valid;
    logic west;
    logic found;
  } srch_ctl_t;

endpackage

/* src/obstacle_avoiding_wire_router_unit.sv */
// Top level of the obstacle-avoiding wire router: route sequencer, output
// register and the chain of obstacle cells. Depends on owr_pkg, owr_cell.
//
//   channel | handshake              | payload
//   in      | in_valid / in_stall    | operation, rect_*, start_*, target_*
//   out     | out_valid / out_stall  | kind, from_x, from_y, to_x, to_y, last
//   cfg     | cfg_valid / cfg_ready  | cfg_data (clearance)
//
// A route makes at most two passes down the cell chain, followed by the
// sequencer steps that emit its results.
// Reset (rst, synchronous) empties the table and sets clearance to 5.
// A stalled output holds the sequencer; input is taken only when idle.
module obstacle_avoiding_wire_router_unit #(
  parameter int MAX_OBSTACLES = 64,
  parameter int COORD_BITS    = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [COORD_BITS-1:0] rect_x,
  input  logic [COORD_BITS-1:0] rect_y,
  input  logic [COORD_BITS-1:0] rect_w,
  input  logic [COORD_BITS-1:0] rect_h,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] target_x,
  input  logic [COORD_BITS-1:0] target_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [15:0]           from_x,
  output logic [15:0]           from_y,
  output logic [15:0]           to_x,
  output logic [15:0]           to_y,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);
  localparam int CW    = COORD_BITS + 3;
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SAME_WAIT, S_SAME_CALC, S_BOT, S_MY, S_EMIT_DET,
    S_DOG_PREP, S_DOG_MID, S_DOG_WAIT, S_DOG_ADJ, S_EMIT_DOG, S_EMIT_ONE
  } state_t;

  typedef logic signed [CW-1:0] crd_t;

  // Halve rounding toward zero
  function automatic crd_t half(input crd_t d);
    crd_t a;
    a = d + ((d < 0) ? crd_t'(1) : crd_t'(0));
    return a >>> 1;
  endfunction

  // Clamp to the 16-bit output range
  function automatic logic [15:0] sat(input crd_t v);
    logic signed [33:0] e;
    e = 34'(v);
    if (e < 0) return 16'd0;
    if (e > 34'sd65535) return 16'hFFFF;
    return e[15:0];
  endfunction

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [7:0]       clearance;
  crd_t             cur_sx, cur_sy, tgt_x, tgt_y, mx, my, piv, dif, bot;
  logic             wdir;
  logic [1:0]       step;
  logic [COORD_BITS-1:0] by, bh;

  // Search launch registers feeding the first cell
  owr_pkg::srch_ctl_t q_ctl;
  crd_t               q_y, q_lo, q_hi;

  // Chain wiring
  owr_pkg::srch_ctl_t    c_ctl [0:MAX_OBSTACLES];
  crd_t                  c_y   [0:MAX_OBSTACLES];
  crd_t                  c_lo  [0:MAX_OBSTACLES];
  crd_t                  c_hi  [0:MAX_OBSTACLES];
  logic [COORD_BITS-1:0] c_bx  [0:MAX_OBSTACLES];
  logic [COORD_BITS-1:0] c_by  [0:MAX_OBSTACLES];
  logic [COORD_BITS-1:0] c_bw  [0:MAX_OBSTACLES];
  logic [COORD_BITS-1:0] c_bh  [0:MAX_OBSTACLES];

  logic out_free, accept, add_go, res_valid, out_load, q_go;
  crd_t re, s_mx, s_hi, s_lo;

  // Emission for the current step
  logic       e_go, e_skip, e_last;
  logic [1:0] e_kind;
  crd_t       e_fx, e_fy, e_tx, e_ty;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign add_go    = accept && (operation == owr_pkg::OP_ADD)
                     && (count < CNT_W'(MAX_OBSTACLES));
  assign cfg_ready = 1'b1;
  assign res_valid = c_ctl[MAX_OBSTACLES].valid;

  // Load the output register on an acknowledge or reject, or an emitted result
  assign out_load  = (accept && ((operation == owr_pkg::OP_CLEAR)
                                 || (operation == owr_pkg::OP_ADD)))
                     || (e_go && !e_skip && out_free);
  // Launch a search down the chain
  assign q_go      = (accept && (operation == owr_pkg::OP_ROUTE)
                      && (start_y == target_y)) || (state == S_DOG_MID);

  assign c_ctl[0] = q_ctl;
  assign c_y[0]   = q_y;
  assign c_lo[0]  = q_lo;
  assign c_hi[0]  = q_hi;
  assign c_bx[0]  = '0;
  assign c_by[0]  = '0;
  assign c_bw[0]  = '0;
  assign c_bh[0]  = '0;

  // Chain of obstacle cells
  for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
    owr_cell #(.COORD_BITS(COORD_BITS), .CNT_W(CNT_W), .INDEX(i)) u_cell (
      .clk(clk), .rst(rst), .add_go(add_go), .count(count),
      .add_x(rect_x), .add_y(rect_y), .add_w(rect_w), .add_h(rect_h),
      .i_ctl(c_ctl[i]), .i_y(c_y[i]), .i_lo(c_lo[i]), .i_hi(c_hi[i]),
      .i_bx(c_bx[i]), .i_by(c_by[i]), .i_bw(c_bw[i]), .i_bh(c_bh[i]),
      .o_ctl(c_ctl[i+1]), .o_y(c_y[i+1]), .o_lo(c_lo[i+1]), .o_hi(c_hi[i+1]),
      .o_bx(c_bx[i+1]), .o_by(c_by[i+1]), .o_bw(c_bw[i+1]), .o_bh(c_bh[i+1])
    );
  end

  // Datapath helpers: right edge of found obstacle, dogleg midpoint window
  always_comb begin
    re   = signed'(CW'(c_bx[MAX_OBSTACLES])) + signed'(CW'(c_bw[MAX_OBSTACLES]));
    s_mx = piv + half(dif);
    s_hi = wdir ? cur_sx : s_mx;
    s_lo = wdir ? s_mx : cur_sx;
  end

  // Pick the result for the current emission step
  always_comb begin
    e_go   = 1'b0;
    e_skip = 1'b0;
    e_last = 1'b0;
    e_kind = owr_pkg::KIND_LINE;
    e_fx   = cur_sx;
    e_fy   = cur_sy;
    e_tx   = tgt_x;
    e_ty   = tgt_y;
    unique case (state)
      S_EMIT_ONE: begin
        e_go   = 1'b1;
        e_last = 1'b1;
      end
      S_EMIT_DET: begin
        e_go = 1'b1;
        if (step == 2'd0) begin
          e_tx = mx;
          e_ty = cur_sy;
        end else begin
          e_fx = mx;
          e_tx = mx;
          e_ty = my;
        end
      end
      S_EMIT_DOG: begin
        e_go = 1'b1;
        case (step)
          2'd0: begin
            e_tx = mx;
            e_ty = cur_sy;
          end
          2'd1: begin
            if (wdir) begin
              e_fx = mx;
              e_tx = mx;
            end else begin
              e_kind = owr_pkg::KIND_POINT;
              e_fx   = mx;
              e_tx   = '0;
              e_ty   = '0;
              e_skip = !(cur_sy > tgt_y);
            end
          end
          2'd2: begin
            if (wdir) begin
              e_kind = owr_pkg::KIND_POINT;
              e_fx   = mx;
              e_fy   = tgt_y;
              e_tx   = '0;
              e_ty   = '0;
              e_skip = !(cur_sy < tgt_y);
            end else begin
              e_fx = mx;
              e_tx = mx;
            end
          end
          default: begin
            e_fx   = mx;
            e_fy   = tgt_y;
            e_last = 1'b1;
          end
        endcase
      end
      default: e_go = 1'b0;
    endcase
  end

  // Sequencer, table count, clearance and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      clearance <= owr_pkg::CLEARANCE_RESET;
      q_ctl     <= '0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      q_ctl.valid <= q_go;
      out_valid   <= out_load || (out_valid && out_stall);
      if (cfg_valid && cfg_ready) clearance <= cfg_data;

      unique case (state) inside
        S_IDLE: begin
          if (accept) begin
            case (operation) inside
              owr_pkg::OP_CLEAR, owr_pkg::OP_ADD: begin
                kind   <= (operation == owr_pkg::OP_ADD && !add_go)
                          ? owr_pkg::KIND_REJECT : owr_pkg::KIND_ACK;
                from_x <= '0;
                from_y <= '0;
                to_x   <= '0;
                to_y   <= '0;
                last   <= 1'b1;
                if (operation == owr_pkg::OP_CLEAR) begin
                  count <= '0;
                end else if (add_go) begin
                  count <= count + CNT_W'(1);
                end
              end
              owr_pkg::OP_ROUTE: begin
                cur_sx <= signed'(CW'(start_x));
                cur_sy <= signed'(CW'(start_y));
                tgt_x  <= signed'(CW'(target_x));
                tgt_y  <= signed'(CW'(target_y));
                if (start_y != target_y) begin
                  state <= S_DOG_PREP;
                end else begin
                  q_ctl.west  <= start_x > target_x;
                  q_ctl.found <= 1'b0;
                  q_y         <= signed'(CW'(start_y));
                  q_hi        <= signed'(CW'((start_x > target_x) ? start_x : target_x));
                  q_lo        <= signed'(CW'((start_x > target_x) ? target_x : start_x));
                  wdir        <= start_x > target_x;
                  state       <= S_SAME_WAIT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SAME_WAIT: begin
          if (res_valid) begin
            by <= c_by[MAX_OBSTACLES];
            bh <= c_bh[MAX_OBSTACLES];
            if (!c_ctl[MAX_OBSTACLES].found) begin
              state <= S_EMIT_ONE;
            end else begin
              piv   <= wdir ? re : cur_sx;
              dif   <= wdir ? (cur_sx - re)
                            : (signed'(CW'(c_bx[MAX_OBSTACLES])) - cur_sx);
              state <= S_SAME_CALC;
            end
          end
        end
        S_SAME_CALC: begin
          mx    <= s_mx;
          state <= S_BOT;
        end
        S_BOT: begin
          bot   <= signed'(CW'(by)) + signed'(CW'(bh));
          state <= S_MY;
        end
        S_MY: begin
          if ((cur_sy - signed'(CW'(by))) < (bot - cur_sy)) begin
            my <= (by >= COORD_BITS'(clearance))
                  ? (signed'(CW'(by)) - signed'(CW'(clearance))) : '0;
          end else begin
            my <= bot + signed'(CW'(clearance));
          end
          step  <= '0;
          state <= S_EMIT_DET;
        end
        S_DOG_PREP: begin
          wdir  <= cur_sx > tgt_x;
          piv   <= (cur_sx > tgt_x) ? tgt_x : cur_sx;
          dif   <= (cur_sx > tgt_x) ? (cur_sx - tgt_x) : (tgt_x - cur_sx);
          state <= S_DOG_MID;
        end
        S_DOG_MID: begin
          mx          <= s_mx;
          q_ctl.west  <= wdir;
          q_ctl.found <= 1'b0;
          q_y         <= cur_sy;
          q_hi        <= s_hi;
          q_lo        <= s_lo;
          state       <= S_DOG_WAIT;
        end
        S_DOG_WAIT: begin
          if (res_valid) begin
            step <= '0;
            if (c_ctl[MAX_OBSTACLES].found) begin
              piv   <= wdir ? re : cur_sx;
              dif   <= wdir ? (cur_sx - re)
                            : (signed'(CW'(c_bx[MAX_OBSTACLES])) - cur_sx);
              state <= S_DOG_ADJ;
            end else begin
              state <= S_EMIT_DOG;
            end
          end
        end
        S_DOG_ADJ: begin
          mx    <= s_mx;
          state <= S_EMIT_DOG;
        end
        S_EMIT_ONE, S_EMIT_DET, S_EMIT_DOG: begin
          if (e_skip) begin
            step <= step + 2'd1;
          end else if (e_go && out_free) begin
            kind   <= e_kind;
            from_x <= sat(e_fx);
            from_y <= sat(e_fy);
            to_x   <= sat(e_tx);
            to_y   <= sat(e_ty);
            last   <= e_last;
            step   <= step + 2'd1;
            if (e_last) begin
              state <= S_IDLE;
            end else if ((state == S_EMIT_DET) && (step == 2'd1)) begin
              cur_sx <= mx;
              cur_sy <= my;
              state  <= S_DOG_PREP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A search result only arrives while the sequencer waits for one
  a_res_in_wait: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == S_SAME_WAIT || state == S_DOG_WAIT))
    else $error("search result outside a wait state");

  // The table count never exceeds its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_OBSTACLES))
    else $error("obstacle count overflow");

  // A stalled result is kept until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
`endif

endmodule

/* src/owr_cell.sv */
// One cell of the obstacle chain: holds one rectangle and refines the search
// token passing through it. Depends on owr_pkg.
module owr_cell #(
  parameter int COORD_BITS = 14,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         add_go,
  input  logic [CNT_W-1:0]             count,
  input  logic [COORD_BITS-1:0]        add_x,
  input  logic [COORD_BITS-1:0]        add_y,
  input  logic [COORD_BITS-1:0]        add_w,
  input  logic [COORD_BITS-1:0]        add_h,
  input  owr_pkg::srch_ctl_t           i_ctl,
  input  logic signed [COORD_BITS+2:0] i_y,
  input  logic signed [COORD_BITS+2:0] i_lo,
  input  logic signed [COORD_BITS+2:0] i_hi,
  input  logic [COORD_BITS-1:0]        i_bx,
  input  logic [COORD_BITS-1:0]        i_by,
  input  logic [COORD_BITS-1:0]        i_bw,
  input  logic [COORD_BITS-1:0]        i_bh,
  output owr_pkg::srch_ctl_t           o_ctl,
  output logic signed [COORD_BITS+2:0] o_y,
  output logic signed [COORD_BITS+2:0] o_lo,
  output logic signed [COORD_BITS+2:0] o_hi,
  output logic [COORD_BITS-1:0]        o_bx,
  output logic [COORD_BITS-1:0]        o_by,
  output logic [COORD_BITS-1:0]        o_bw,
  output logic [COORD_BITS-1:0]        o_bh
);
  localparam int CW = COORD_BITS + 3;

  logic [COORD_BITS-1:0] rx, ry, rw, rh;
  logic                  live, blk, better, take;
  logic signed [CW-1:0]  ex, ey, ex_end, ey_end, ebx, eb_end;

  // Store the rectangle when this is the next free slot
  always_ff @(posedge clk) begin
    if (add_go && (count == CNT_W'(INDEX))) begin
      rx <= add_x;
      ry <= add_y;
      rw <= add_w;
      rh <= add_h;
    end
  end

  // Test the entry against the token
  always_comb begin
    live   = count > CNT_W'(INDEX);
    ex     = signed'({3'b000, rx});
    ey     = signed'({3'b000, ry});
    ex_end = ex + signed'({3'b000, rw});
    ey_end = ey + signed'({3'b000, rh});
    ebx    = signed'({3'b000, i_bx});
    eb_end = ebx + signed'({3'b000, i_bw});
    blk    = live && (ex < i_hi) && (ex_end > i_lo) && (ey < i_y) && (ey_end > i_y);
    better = !i_ctl.found || (i_ctl.west ? (ex_end > eb_end) : (ex < ebx));
    take   = i_ctl.valid && blk && better;
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      o_ctl <= '0;
    end else begin
      o_ctl.valid <= i_ctl.valid;
      o_ctl.west  <= i_ctl.west;
      o_ctl.found <= i_ctl.found || take;
    end
    o_y  <= i_y;
    o_lo <= i_lo;
    o_hi <= i_hi;
    o_bx <= take ? rx : i_bx;
    o_by <= take ? ry : i_by;
    o_bw <= take ? rw : i_bw;
    o_bh <= take ? rh : i_bh;
  end

endmodule

/* verif/owr_checker.sv */
// Result checker for the obstacle-avoiding wire router: watches the input,
// output and clearance channels, predicts route segments and compares them.
// Depends on owr_pkg.
module owr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [13:0] rect_x,
  input  logic [13:0] rect_y,
  input  logic [13:0] rect_w,
  input  logic [13:0] rect_h,
  input  logic [13:0] start_x,
  input  logic [13:0] start_y,
  input  logic [13:0] target_x,
  input  logic [13:0] target_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] from_x,
  input  logic [15:0] from_y,
  input  logic [15:0] to_x,
  input  logic [15:0] to_y,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          segs_seen,
  output int          detours_seen
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] tx;
    logic [15:0] ty;
    logic        last;
  } seg_t;

  seg_t        seg_queue[$];
  longint      obs_x[64], obs_y[64], obs_w[64], obs_h[64];
  int          obs_count;
  logic [7:0]  clear_margin;

  assign pending = seg_queue.size();

  function automatic logic [15:0] clip(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic void push_seg(logic [1:0] k, longint fx, longint fy,
                                   longint tx, longint ty);
    seg_queue.push_back({k, clip(fx), clip(fy), clip(tx), clip(ty), 1'b0});
  endfunction

  // Nearest blocking obstacle going west: largest right edge, first wins
  function automatic int nearest_west(longint y, longint sx, longint tx);
    int best;
    best = -1;
    for (int i = 0; i < obs_count; i++) begin
      if (obs_x[i] >= sx || obs_x[i] + obs_w[i] <= tx) continue;
      if (obs_y[i] >= y || obs_y[i] + obs_h[i] <= y) continue;
      if (best < 0 || obs_x[i] + obs_w[i] > obs_x[best] + obs_w[best]) best = i;
    end
    return best;
  endfunction

  // Nearest blocking obstacle going east: smallest left edge, first wins
  function automatic int nearest_east(longint y, longint sx, longint tx);
    int best;
    best = -1;
    for (int i = 0; i < obs_count; i++) begin
      if (obs_x[i] >= tx || obs_x[i] + obs_w[i] <= sx) continue;
      if (obs_y[i] >= y || obs_y[i] + obs_h[i] <= y) continue;
      if (best < 0 || obs_x[i] < obs_x[best]) best = i;
    end
    return best;
  endfunction

  function automatic void predict_dogleg(longint sx, longint sy, longint tx, longint ty);
    longint mx, re;
    int b;
    if (sx > tx) begin
      mx = tx + (sx - tx) / 2;
      b = nearest_west(sy, sx, mx);
      if (b >= 0) begin
        re = obs_x[b] + obs_w[b];
        mx = re + (sx - re) / 2;
      end
      push_seg(owr_pkg::KIND_LINE, sx, sy, mx, sy);
      push_seg(owr_pkg::KIND_LINE, mx, sy, mx, ty);
      if (sy < ty) push_seg(owr_pkg::KIND_POINT, mx, ty, 0, 0);
      push_seg(owr_pkg::KIND_LINE, mx, ty, tx, ty);
    end else begin
      mx = sx + (tx - sx) / 2;
      b = nearest_east(sy, sx, mx);
      if (b >= 0) mx = sx + (obs_x[b] - sx) / 2;
      push_seg(owr_pkg::KIND_LINE, sx, sy, mx, sy);
      if (sy > ty) push_seg(owr_pkg::KIND_POINT, mx, sy, 0, 0);
      push_seg(owr_pkg::KIND_LINE, mx, sy, mx, ty);
      push_seg(owr_pkg::KIND_LINE, mx, ty, tx, ty);
    end
  endfunction

  function automatic void predict_route(longint sx, longint sy, longint tx, longint ty);
    longint mx, my, clr;
    int b;
    if (sy != ty) begin
      predict_dogleg(sx, sy, tx, ty);
      return;
    end
    if (sx > tx) begin
      b = nearest_west(sy, sx, tx);
      if (b >= 0) mx = obs_x[b] + obs_w[b] + (sx - obs_x[b] - obs_w[b]) / 2;
    end else begin
      b = nearest_east(sy, sx, tx);
      if (b >= 0) mx = sx + (obs_x[b] - sx) / 2;
    end
    if (b < 0) begin
      push_seg(owr_pkg::KIND_LINE, sx, sy, tx, ty);
      return;
    end
    detours_seen++;
    clr = longint'(clear_margin);
    if (sy - obs_y[b] < obs_y[b] + obs_h[b] - sy)
      my = (obs_y[b] >= clr) ? obs_y[b] - clr : 0;
    else
      my = obs_y[b] + obs_h[b] + clr;
    push_seg(owr_pkg::KIND_LINE, sx, sy, mx, sy);
    push_seg(owr_pkg::KIND_LINE, mx, sy, mx, my);
    predict_dogleg(mx, my, tx, ty);
  endfunction

  // Predict on accepted items, compare accepted results
  always @(posedge clk) begin
    seg_t got, exp_seg;
    int   n0;
    if (rst) begin
      obs_count    = 0;
      clear_margin = owr_pkg::CLEARANCE_RESET;
      seg_queue.delete();
      fail_count   = 0;
      segs_seen    = 0;
      detours_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) clear_margin = cfg_data;
      if (in_valid && !in_stall) begin
        n0 = seg_queue.size();
        case (operation)
          owr_pkg::OP_CLEAR: begin
            obs_count = 0;
            push_seg(owr_pkg::KIND_ACK, 0, 0, 0, 0);
          end
          owr_pkg::OP_ADD: begin
            if (obs_count < 64) begin
              obs_x[obs_count] = longint'(rect_x);
              obs_y[obs_count] = longint'(rect_y);
              obs_w[obs_count] = longint'(rect_w);
              obs_h[obs_count] = longint'(rect_h);
              obs_count = obs_count + 1;
              push_seg(owr_pkg::KIND_ACK, 0, 0, 0, 0);
            end else begin
              push_seg(owr_pkg::KIND_REJECT, 0, 0, 0, 0);
            end
          end
          owr_pkg::OP_ROUTE: predict_route(longint'(start_x), longint'(start_y),
                                           longint'(target_x), longint'(target_y));
          default: ;
        endcase
        // Keep at most six results and mark the final one
        while (seg_queue.size() - n0 > 6) void'(seg_queue.pop_back());
        if (seg_queue.size() > n0) seg_queue[seg_queue.size() - 1].last = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = {kind, from_x, from_y, to_x, to_y, last};
        segs_seen = segs_seen + 1;
        if (seg_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count = fail_count + 1;
        end else begin
          exp_seg = seg_queue.pop_front();
          if (got !== exp_seg) begin
            $display("%0t: mismatch kind/from_x/from_y/to_x/to_y/last expected %0d %0d %0d %0d %0d %0d actual %0d %0d %0d %0d %0d %0d",
                     $time, exp_seg.kind, exp_seg.fx, exp_seg.fy, exp_seg.tx, exp_seg.ty,
                     exp_seg.last, kind, from_x, from_y, to_x, to_y, last);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* verif/tb_obstacle_avoiding_wire_router_unit.sv */
// Stimulus and verdict for the obstacle-avoiding wire router: obstacle
// tables, routes and clearance settings. Depends on owr_pkg, owr_checker, the RTL.
module tb_obstacle_avoiding_wire_router_unit;

  localparam int IDLE_LIMIT = 20000;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [1:0]  operation;
  logic [13:0] rect_x, rect_y, rect_w, rect_h;
  logic [13:0] start_x, start_y, target_x, target_y;
  logic        out_valid, out_stall;
  logic [1:0]  kind;
  logic [15:0] from_x, from_y, to_x, to_y;
  logic        last;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_data;
  int          fail_count, pending, segs_seen, detours_seen;
  int          idle_cycles;
  int          stall_left;
  bit          stall_quiet;

  obstacle_avoiding_wire_router_unit dut (.*);

  owr_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [13:0] rnd14();
    return 14'($urandom);
  endfunction

  // Receiver stalls for random stretches, with quiet phases
  always @(negedge clk) begin
    if (rst || stall_quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= gap_len();
    end
  end

  // Watchdog on cycles with no accepted item or result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_obstacle_avoiding_wire_router_unit NOT OK");
        $finish;
      end
    end
  end

  // Drive one item and hold it until accepted; valid drops only on a gap
  task automatic send(logic [1:0] op, logic [13:0] a, logic [13:0] b,
                      logic [13:0] c, logic [13:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    operation <= op;
    rect_x <= a; rect_y <= b; rect_w <= c; rect_h <= d;
    start_x <= a; start_y <= b; target_x <= c; target_y <= d;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_then_config(logic [7:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [13:0] near(int c, int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return v[13:0];
  endfunction

  task automatic random_phase(int n);
    int r, cx, cy;
    logic [13:0] ry, sx, tx;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      cx = $urandom_range(0, 16383);
      cy = $urandom_range(0, 16383);
      if (r < 3) send(owr_pkg::OP_CLEAR, rnd14(), rnd14(), rnd14(), rnd14());
      else if (r < 5) send(owr_pkg::OP_NONE, rnd14(), rnd14(), rnd14(), rnd14());
      else if (r < 35) begin
        if ($urandom_range(0, 9) == 0)
          send(owr_pkg::OP_ADD, rnd14(), rnd14(), rnd14(), rnd14());
        else
          send(owr_pkg::OP_ADD, near(cx, 4000), near(cy, 4000),
               14'($urandom_range(0, 3000)), 14'($urandom_range(0, 3000)));
      end else if (r < 70) begin
        // Same-row route likely to cross a stored obstacle
        ry = near(cy, 3000);
        sx = rnd14();
        tx = rnd14();
        send(owr_pkg::OP_ROUTE, sx, ry, tx, ry);
      end else begin
        send(owr_pkg::OP_ROUTE, rnd14(), rnd14(), rnd14(), rnd14());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; cfg_valid = 1'b0; cfg_data = 8'd0;
    operation = owr_pkg::OP_CLEAR;
    {rect_x, rect_y, rect_w, rect_h} = '0;
    {start_x, start_y, target_x, target_y} = '0;
    stall_quiet = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: straight lines, detours over and under, doglegs, extremes
    send(owr_pkg::OP_ROUTE, 14'd100, 14'd50, 14'd900, 14'd50);
    send(owr_pkg::OP_ADD, 14'd400, 14'd40, 14'd100, 14'd40);
    send(owr_pkg::OP_ADD, 14'd400, 14'd10, 14'd50, 14'd100);
    send(owr_pkg::OP_ROUTE, 14'd100, 14'd50, 14'd900, 14'd50);
    send(owr_pkg::OP_ROUTE, 14'd900, 14'd50, 14'd100, 14'd50);
    send(owr_pkg::OP_ROUTE, 14'd100, 14'd70, 14'd900, 14'd70);
    send(owr_pkg::OP_ROUTE, 14'd450, 14'd60, 14'd450, 14'd60);
    send(owr_pkg::OP_ROUTE, 14'd100, 14'd50, 14'd900, 14'd300);
    send(owr_pkg::OP_ROUTE, 14'd900, 14'd50, 14'd100, 14'd30);
    send(owr_pkg::OP_ROUTE, 14'd900, 14'd30, 14'd100, 14'd50);
    send(owr_pkg::OP_ROUTE, 14'd100, 14'd300, 14'd900, 14'd50);
    send(owr_pkg::OP_ADD, 14'd0, 14'd0, 14'h3FFF, 14'h3FFF);
    send(owr_pkg::OP_ROUTE, 14'd0, 14'd2, 14'h3FFF, 14'd2);
    send(owr_pkg::OP_ROUTE, 14'h3FFF, 14'h3FFE, 14'd0, 14'h3FFE);
    send(owr_pkg::OP_NONE, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
    send(owr_pkg::OP_CLEAR, 14'd0, 14'd0, 14'd0, 14'd0);
    for (int i = 0; i < 65; i++)
      send(owr_pkg::OP_ADD, 14'(i * 200), 14'd1000, 14'd50, 14'd20);
    send(owr_pkg::OP_ROUTE, 14'd0, 14'd1010, 14'h3FFF, 14'd1010);
    send(owr_pkg::OP_CLEAR, 14'd0, 14'd0, 14'd0, 14'd0);

    // Random phases across clearance settings
    drain_then_config(8'd0);
    random_phase(80);
    drain_then_config(8'd255);
    stall_quiet = 1'b1;
    random_phase(80);
    stall_quiet = 1'b0;
    drain_then_config(8'($urandom_range(1, 254)));
    random_phase(80);
    drain_then_config(8'd5);
    random_phase(90);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    $display("Covered %0d results, %0d detours, clearance 0, 255 and mid values.",
             segs_seen, detours_seen);
    if (fail_count == 0) $display("tb_obstacle_avoiding_wire_router_unit OK");
    else $display("tb_obstacle_avoiding_wire_router_unit NOT OK");
    $finish;
  end
endmodule
